[rtl/sma_pkg.sv]
// shared types and constants for the simple moving average block
package sma_pkg;

   localparam int WINDOW_MAX = 256;
   localparam int PRICE_W    = 32;
   localparam int TIME_W     = 63;
   localparam int WLEN_W     = 9;
   localparam int SLOT_W     = $clog2(WINDOW_MAX);
   localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W      = PRICE_W + $clog2(WINDOW_MAX);

   typedef logic [PRICE_W-1:0] price_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [WLEN_W-1:0]  wlen_type;
   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SUM_W-1:0]   sum_type;

endpackage

[rtl/sma_req_if.sv]
// input channel: one price sample per item
interface sma_req_if;
   import sma_pkg::*;

   logic      valid;
   logic      ready;
   price_type close_price;
   time_type  sample_time;
   logic      restart;

   modport source (output valid, close_price, sample_time, restart, input ready);
   modport sink (input valid, close_price, sample_time, restart, output ready);
endinterface

[rtl/sma_rsp_if.sv]
// result channel: timestamp and average per item
interface sma_rsp_if;
   import sma_pkg::*;

   logic      valid;
   logic      ready;
   time_type  avg_time;
   price_type average;

   modport source (output valid, avg_time, average, input ready);
   modport sink (input valid, avg_time, average, output ready);
endinterface

[rtl/sma_csr_if.sv]
// configuration write channel for the window length register
interface sma_csr_if;
   import sma_pkg::*;

   logic     valid;
   logic     ready;
   wlen_type window_length;

   modport source (output valid, window_length, input ready);
   modport sink (input valid, window_length, output ready);
endinterface

[rtl/simple_moving_average.sv]
// simple moving average with warm-up: price ring memory, running sum, serial divide
// an accepted item passes through the accept with its ring read, the update and write-back,
//   the serial divide and the output load before its result is shown on rsp_ch
// a new item is taken only in the idle state, once the previous result has been loaded
// reset clears running sum, fill count and write slot and sets window length to 1
// the price ring is not cleared: only entries written since the last restart are read
module simple_moving_average (
   input logic       clock,
   input logic       reset,
   sma_req_if.sink   req_ch,
   sma_rsp_if.source rsp_ch,
   sma_csr_if.sink   csr_ch
);
   import sma_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      UPD,
      DIV,
      OUT
   } state_type;

   state_type state_ff;

   // configuration and series state
   wlen_type  window_ff;
   sum_type   sum_ff;
   count_type fill_ff;
   slot_type  slot_ff;

   // per-item work registers
   price_type price_ff;
   time_type  time_ff;
   logic      evict_ff;
   price_type rd_data_ff;

   // result register
   logic      rsp_valid_ff;
   time_type  rsp_time_ff;
   price_type rsp_avg_ff;

   // price ring
   price_type price_mem [WINDOW_MAX];

   logic      req_acc;
   count_type win_eff;
   count_type fill_eff;
   slot_type  slot_eff;
   count_type back_cnt;
   count_type slot_ext;
   count_type rd_cnt;
   slot_type  rd_addr;
   logic      evict_in;
   sum_type   sum_in;
   count_type fill_in;
   slot_type  slot_in;
   logic      div_start;
   logic      div_done;
   price_type div_quo;

   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == IDLE);
   assign csr_ch.ready = 1'b1;

   // accept side: clamp the window, apply restart, find the oldest entry
   always_comb begin
      if (window_ff == '0) begin
         win_eff = COUNT_W'(1);
      end else if (COUNT_W'(window_ff) > COUNT_W'(WINDOW_MAX)
                   || (WLEN_W > COUNT_W && window_ff > WLEN_W'(WINDOW_MAX))) begin
         win_eff = COUNT_W'(WINDOW_MAX);
      end else begin
         win_eff = COUNT_W'(window_ff);
      end

      fill_eff = req_ch.restart ? '0 : fill_ff;
      slot_eff = req_ch.restart ? '0 : slot_ff;
      evict_in = fill_eff >= win_eff;

      // oldest sample sits fill entries behind the write slot, modulo the ring
      back_cnt = (fill_eff == COUNT_W'(WINDOW_MAX)) ? '0 : fill_eff;
      slot_ext = COUNT_W'(slot_eff);
      if (slot_ext >= back_cnt) begin
         rd_cnt = slot_ext - back_cnt;
      end else begin
         rd_cnt = slot_ext + COUNT_W'(WINDOW_MAX) - back_cnt;
      end
      rd_addr = rd_cnt[SLOT_W-1:0];
   end

   // update side: drop the oldest price once the window is full, add the new one
   always_comb begin
      sum_in  = sum_ff - (evict_ff ? SUM_W'(rd_data_ff) : '0) + SUM_W'(price_ff);
      fill_in = evict_ff ? fill_ff : fill_ff + 1'b1;
      slot_in = (slot_ff == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_ff + 1'b1;
   end

   assign div_start = (state_ff == UPD);

   // ring read at accept, write-back in the update cycle; the next read comes
   // only with the next item, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_data_ff <= price_mem[rd_addr];
      end
      if (state_ff == UPD) begin
         price_mem[slot_ff] <= price_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         window_ff    <= WLEN_W'(1);
         sum_ff       <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            window_ff <= csr_ch.window_length;
         end
         // in the output state the load below decides the result valid
         if (rsp_valid_ff && rsp_ch.ready && state_ff != OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_acc) begin
                  price_ff <= req_ch.close_price;
                  time_ff  <= req_ch.sample_time;
                  evict_ff <= evict_in;
                  // restart clears the series before this sample is used
                  if (req_ch.restart) begin
                     sum_ff  <= '0;
                     fill_ff <= '0;
                     slot_ff <= '0;
                  end
                  state_ff <= UPD;
               end
            end
            UPD: begin
               sum_ff   <= sum_in;
               fill_ff  <= fill_in;
               slot_ff  <= slot_in;
               state_ff <= DIV;
            end
            DIV: begin
               if (div_done) begin
                  state_ff <= OUT;
               end
            end
            OUT: begin
               // result register frees up the cycle the sink takes the old item
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_time_ff  <= time_ff;
                  rsp_avg_ff   <= div_quo;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.avg_time = rsp_time_ff;
   assign rsp_ch.average  = rsp_avg_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_W'(WINDOW_MAX))
      else $error("fill count above ring depth");

   // the sum holds at most fill prices of full scale
   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      (COUNT_W + PRICE_W)'(sum_ff)
         <= ({fill_ff, {PRICE_W{1'b0}}} - (COUNT_W + PRICE_W)'(fill_ff)))
      else $error("running sum exceeds fill count times max price");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPD) |-> (fill_in != '0))
      else $error("divide started with zero count");

   a_out_after_done: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == DIV) && (state_ff == OUT)) |-> $past(div_done))
      else $error("result stage entered before divide finished");
`endif
endmodule

[rtl/sma_div.sv]
// serial restoring divider, one quotient bit per cycle
module sma_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  sma_pkg::sum_type   dividend,
   input  sma_pkg::count_type divisor,
   output logic               done,
   output sma_pkg::price_type quotient
);
   import sma_pkg::*;

   localparam int ITER_W = $clog2(SUM_W);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [ITER_W-1:0] iter_ff;
   count_type         rem_ff;
   count_type         rem_in;
   sum_type           quo_ff;
   count_type         dvs_ff;
   logic [COUNT_W:0]  trial;
   logic              fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? COUNT_W'(trial - {1'b0, dvs_ff}) : trial[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_LAST;
         end else if (busy_ff) begin
            if (iter_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            iter_ff <= iter_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[PRICE_W-1:0];

`ifndef SYNTHESIS
   // a mean of prices never exceeds the largest price
   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> quo_ff[SUM_W-1:PRICE_W] == '0)
      else $error("quotient overflows price width");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");
`endif
endmodule

[test/simple_moving_average_tb.sv]
// self-checking testbench for the simple moving average block
`timescale 1ns / 1ps

module simple_moving_average_tb;
   import sma_pkg::*;

   // run limit: many times what the block needs for all the items
   localparam int CYCLE_LIMIT  = 1000000;
   // cycles to let pass once the last result is in, a bit over the block latency
   localparam int SETTLE_WAIT  = 50;
   localparam int IDLE_PERCENT = 22;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      price_type close_price;
      time_type  sample_time;
      logic      restart;
   } price_sample_type;

   typedef struct packed {
      time_type  stamp;
      price_type average;
   } average_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // testbench-side copies of the block inputs, known from time zero
   logic      req_valid   = 1'b0;
   price_type req_price   = '0;
   time_type  req_stamp   = '0;
   logic      req_restart = 1'b0;
   logic      rsp_ready   = 1'b0;
   logic      csr_valid   = 1'b0;
   wlen_type  csr_data    = '0;

   // no idling on either side while this is high
   logic steady = 1'b0;
   // set at a rising edge where the request item was taken
   logic req_taken = 1'b0;

   sma_req_if req_ch ();
   sma_rsp_if rsp_ch ();
   sma_csr_if csr_ch ();

   assign req_ch.valid       = req_valid;
   assign req_ch.close_price = req_price;
   assign req_ch.sample_time = req_stamp;
   assign req_ch.restart     = req_restart;
   assign rsp_ch.ready       = rsp_ready;
   assign csr_ch.valid       = csr_valid;
   assign csr_ch.window_length = csr_data;

   simple_moving_average dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // samples waiting to be sent, and averages waiting to come back
   price_sample_type   pending_samples[$];
   average_result_type expected_averages[$];

   // own copy of the averaging state, same reset as the block
   price_type ring_prices [WINDOW_MAX];
   sum_type   window_sum   = '0;
   count_type sample_count = '0;
   slot_type  next_slot    = '0;
   wlen_type  window_setting = WLEN_W'(1);

   int cycle_count    = 0;
   int mismatch_count = 0;
   int samples_sent   = 0;
   int averages_seen  = 0;
   int window_writes  = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // run guard: the counter ends a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d averages still due", cycle_count,
               expected_averages.size());
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // fold one sample into the running sum and give the truncated mean
   task automatic track_sample(input price_type price, input logic restart,
                               output price_type average);
      count_type span;
      slot_type  oldest;
      sum_type   quotient;
      if (restart) begin
         window_sum   = '0;
         sample_count = '0;
         next_slot    = '0;
      end
      // a length of zero acts as one, anything past the ring size as the ring size
      span = (window_setting == 0) ? count_type'(1) : count_type'(window_setting);
      if (span > WINDOW_MAX) begin
         span = count_type'(WINDOW_MAX);
      end
      if (sample_count < span) begin
         // warm-up, or the window was grown: add without eviction
         sample_count++;
      end else begin
         // window full: drop the price sample_count entries back in the ring
         oldest     = next_slot - slot_type'(sample_count);
         window_sum = window_sum - sum_type'(ring_prices[oldest]);
      end
      window_sum             = window_sum + sum_type'(price);
      ring_prices[next_slot] = price;
      next_slot              = next_slot + 1'b1;
      quotient               = window_sum / sum_type'(sample_count);
      average                = quotient[PRICE_W-1:0];
   endtask

   // request side: a taken item gets its expected average right away
   always @(posedge clock) begin : req_monitor
      average_result_type want;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         want.stamp = req_ch.sample_time;
         track_sample(req_ch.close_price, req_ch.restart, want.average);
         expected_averages.insert(expected_averages.size(), want);
         samples_sent++;
      end
   end

   // request driver: moves to the next item once the current one is taken
   always @(negedge clock) begin : req_driver
      price_sample_type next_item;
      logic             gap;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         gap = !steady && ($urandom_range(99) < IDLE_PERCENT);
         if (!gap && pending_samples.size() != 0) begin
            next_item   = pending_samples.pop_front();
            req_price   <= next_item.close_price;
            req_stamp   <= next_item.sample_time;
            req_restart <= next_item.restart;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stalls at random
   always @(negedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);
   end

   // result checker: compare against the oldest expected average
   always @(posedge clock) begin : rsp_monitor
      average_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         averages_seen++;
         if (expected_averages.size() == 0) begin
            report_mismatch($sformatf("unexpected item: stamp %h average %h",
                                      rsp_ch.avg_time, rsp_ch.average));
         end else begin
            want = expected_averages.pop_front();
            if (rsp_ch.avg_time !== want.stamp) begin
               report_mismatch($sformatf("stamp expected %h got %h",
                                         want.stamp, rsp_ch.avg_time));
            end
            if (rsp_ch.average !== want.average) begin
               report_mismatch($sformatf("average expected %h got %h (stamp %h)",
                                         want.average, rsp_ch.average, want.stamp));
            end
         end
      end
   end

   task automatic add_item(input price_type price, input time_type stamp, input logic restart);
      price_sample_type item;
      item.close_price = price;
      item.sample_time = stamp;
      item.restart     = restart;
      pending_samples.insert(pending_samples.size(), item);
   endtask

   // wait until every sent item has its result, then let the pipeline settle
   task automatic drain();
      while (pending_samples.size() != 0 || req_valid || expected_averages.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // window length write, only once the block is idle
   task automatic set_window(input wlen_type length);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= length;
      forever begin
         @(posedge clock);
         if (csr_ch.ready) begin
            break;
         end
      end
      window_setting = length;
      window_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // a series with random prices, mostly long runs and an odd restart
   task automatic random_series(input int count, input logic restart_first);
      price_type price;
      time_type  stamp;
      logic      restart;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: price = '0;
            1: price = '1;
            2: price = 32'hFFFF_FF00 | 32'($urandom_range(255));
            3: price = 32'($urandom_range(65535));
            default: price = $urandom;
         endcase
         stamp   = time_type'({$urandom, $urandom});
         restart = (n == 0) ? restart_first : ($urandom_range(149) == 0);
         add_item(price, stamp, restart);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window of one, first sample with no restart, field extremes
      add_item('0, '0, 1'b0);
      add_item('1, '1, 1'b0);
      add_item(32'h8000_0001, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1);

      // full-scale prices so the sum runs past 32 bits, with eviction
      set_window(9'd3);
      add_item('1, 63'd10, 1'b1);
      add_item('1, 63'd11, 1'b0);
      add_item('1, 63'd12, 1'b0);
      add_item('1, 63'd13, 1'b0);

      // zero length acts as one
      set_window(9'd0);
      add_item(32'h0000_0300, 63'd20, 1'b0);
      add_item(32'h0000_0101, 63'd21, 1'b0);

      // window grown mid-series resumes warm-up, shrunk keeps its count
      set_window(9'd2);
      add_item(32'h0000_0100, 63'd30, 1'b1);
      add_item(32'h0000_0200, 63'd31, 1'b0);
      add_item(32'h0000_0700, 63'd32, 1'b0);
      set_window(9'd5);
      add_item(32'h0000_0900, 63'd33, 1'b0);
      add_item(32'h0000_0003, 63'd34, 1'b0);
      add_item(32'h0001_0000, 63'd35, 1'b0);
      set_window(9'd2);
      add_item(32'h0000_0001, 63'd36, 1'b0);
      add_item(32'h0000_0002, 63'd37, 1'b0);
      add_item(32'hFFFF_FFFF, 63'd38, 1'b0);

      // length past the ring size is clamped
      set_window(9'd511);
      add_item(32'h1234_5678, '1, 1'b1);
      add_item(32'h8765_4321, 63'd40, 1'b0);
      add_item('0, 63'd41, 1'b0);

      // random part: a full ring with no idling, then the extremes, then mixed lengths
      set_window(9'd256);
      steady = 1'b1;
      random_series(400, 1'b1);
      drain();
      steady = 1'b0;
      set_window(9'd511);
      random_series(300, 1'b1);
      set_window(9'd1);
      random_series(120, 1'($urandom_range(1)));
      set_window(9'd0);
      random_series(60, 1'b0);
      for (int phase = 0; phase < 8; phase++) begin
         set_window(wlen_type'($urandom_range(511)));
         random_series(130, 1'($urandom_range(1)));
      end

      drain();
      $display("sent %0d samples over %0d window writes, checked %0d averages",
               samples_sent, window_writes, averages_seen);
      $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0 && expected_averages.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/sma_pkg.sv
rtl/sma_req_if.sv
rtl/sma_rsp_if.sv
rtl/sma_csr_if.sv
rtl/sma_div.sv
rtl/simple_moving_average.sv
test/simple_moving_average_tb.sv
